@@ hw/rtl/baldp_pkg.sv @@
// Shared types and constants for the two-objective alignment grid block.
package baldp_pkg;

	// Grid geometry limits
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int COL_W    = $clog2(MAX_COLS);   // column address bits
	localparam int CNT_W    = COL_W + 1;          // column count, holds MAX_COLS itself
	localparam int ROW_W    = $clog2(MAX_ROWS);   // row counter bits

	// Cell value widths
	localparam int M_W    = 18;
	localparam int D_W    = 12;
	localparam int W_W    = 8;
	localparam int RANK_W = M_W + W_W + 2;

	localparam logic signed [M_W-1:0] M_MAX = {1'b0, {(M_W-1){1'b1}}};
	localparam logic signed [M_W-1:0] M_MIN = {1'b1, {(M_W-1){1'b0}}};
	localparam logic [D_W-1:0]        D_MAX = {D_W{1'b1}};

	// Selection modes
	localparam logic [1:0] MODE_LEX_MATCH = 2'd0;
	localparam logic [1:0] MODE_LEX_INDEL = 2'd1;
	localparam logic [1:0] MODE_WEIGHTED  = 2'd2;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MODE  = 2'd0,
		REG_WM    = 2'd1,
		REG_WI    = 2'd2,
		REG_COLS  = 2'd3
	} reg_idx_t;

	// One grid cell: match score and indel count
	typedef struct packed {
		logic signed [M_W-1:0] m;
		logic [D_W-1:0]        d;
	} pair_t;

endpackage

@@ hw/rtl/biobjective_alignment_bound_dp.sv @@
// Top level of the two-objective alignment grid block: one cell per request.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] score, s_tlast last_cell
//  m_*     | out | m_tvalid/m_tready  | m_tdata[17:0] final_matches, [29:18] final_indels
//  cfg_*   | in  | cfg_we             | cfg_index register, cfg_data value
//
// One cell per cycle sustained; a last cell waiting on a full output stalls intake.
// The rate is set by the left-neighbor loop: the chosen pair of one cell feeds the
// next cell's left candidate through a single compare-and-select stage. The row
// buffer is read at acceptance, with the current write forwarded when both address
// the same column. Reset clears counters, neighbor registers and config; the row
// buffer is not cleared. Only a last cell loads the result register.
module biobjective_alignment_bound_dp
	import baldp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] score
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [17:0] final_matches, [29:18] final_indels
);

	// Weighted rank of a pair: wm*m - wi*d
	function automatic logic signed [RANK_W-1:0] rank_of(pair_t p, logic [W_W-1:0] wm,
			logic [W_W-1:0] wi);
		logic signed [W_W:0]           wm_s;
		logic signed [M_W+W_W:0]       pm;
		logic [D_W+W_W-1:0]            pd;
		wm_s = $signed({1'b0, wm});
		pm   = wm_s * p.m;
		pd   = wi * p.d;
		return RANK_W'(pm) - $signed(RANK_W'(pd));
	endfunction

	// True when a is strictly better than b in the given mode
	function automatic logic better(pair_t a, pair_t b, logic signed [RANK_W-1:0] ra,
			logic signed [RANK_W-1:0] rb, logic [1:0] md);
		logic res;
		case (md)
			MODE_LEX_INDEL: res = (a.d != b.d) ? (a.d < b.d) : (a.m > b.m);
			MODE_WEIGHTED:  res = ra > rb;
			default:        res = (a.m != b.m) ? (a.m > b.m) : (a.d < b.d);
		endcase
		return res;
	endfunction

	// Configuration registers
	logic [1:0]       mode_q;
	logic [W_W-1:0]   wm_q;
	logic [W_W-1:0]   wi_q;
	logic [CNT_W-1:0] cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LEX_MATCH;
			wm_q   <= W_W'(1);
			wi_q   <= W_W'(1);
			cols_q <= CNT_W'(MAX_COLS);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE: mode_q <= cfg_data[1:0];
				REG_WM:   wm_q   <= cfg_data[W_W-1:0];
				REG_WI:   wi_q   <= cfg_data[W_W-1:0];
				REG_COLS: cols_q <= cfg_data[CNT_W-1:0];
				default:  ;
			endcase
		end
	end

	// Handshake and stage control
	logic s_accept;
	logic s1_valid;
	logic s1_go;
	logic last_s1;

	assign s1_go    = s1_valid && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !s1_valid || s1_go;
	assign s_accept = s_tvalid && s_tready;

	// Grid position at intake
	logic [CNT_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] nc;
	logic [CNT_W-1:0] j_cur;
	logic [CNT_W-1:0] j_inc;

	always_comb begin
		if (cols_q == '0)
			nc = CNT_W'(1);
		else if (cols_q > CNT_W'(MAX_COLS))
			nc = CNT_W'(MAX_COLS);
		else
			nc = cols_q;
		j_cur = (col_q >= nc) ? '0 : col_q;
		j_inc = j_cur + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_accept) begin
			if (s_tlast) begin
				col_q <= '0;
				row_q <= '0;
			end else if (j_inc >= nc) begin
				col_q <= '0;
				if (row_q < ROW_W'(MAX_ROWS - 1))
					row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= j_inc;
			end
		end
	end

	// Input stage registers
	logic signed [7:0] score_s1;
	logic [COL_W-1:0]  j_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              byp_s1;
	pair_t             byp_data_s1;
	pair_t             rd_s1;
	pair_t             best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			last_s1  <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (s_accept) begin
			s1_valid <= 1'b1;
			last_s1  <= s_tlast;
			byp_s1   <= s1_go && (j_s1 == j_cur[COL_W-1:0]);
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			score_s1    <= $signed(s_tdata);
			j_s1        <= j_cur[COL_W-1:0];
			row_s1      <= row_q;
			byp_data_s1 <= best;
		end
	end

	// Row buffer: read at intake, written with the chosen pair
	pair_t row_mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (s_accept)
			rd_s1 <= row_mem[j_cur[COL_W-1:0]];
		if (s1_go)
			row_mem[j_s1] <= best;
	end

	// Neighbor registers
	pair_t left_q;
	pair_t diag_q;
	pair_t up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
		end else if (s1_go) begin
			diag_q <= up;
			left_q <= best;
		end
	end

	// Candidate selection
	pair_t                    lf, dg, cu, cl, cd, best1;
	logic [1:0]               md;
	logic signed [M_W:0]      dsum;
	logic signed [RANK_W-1:0] r_cu, r_cl, r_cd, r_best1;

	always_comb begin
		// the spare mode code acts as most-matches
		md = (mode_q > MODE_WEIGHTED) ? MODE_LEX_MATCH : mode_q;

		// borders
		if (j_s1 == '0) begin
			lf.m = '0;
			lf.d = D_W'(row_s1) + D_W'(1);
			dg.m = '0;
			dg.d = D_W'(row_s1);
		end else begin
			lf = left_q;
			dg = diag_q;
		end
		if (row_s1 == '0) begin
			up.m = '0;
			up.d = D_W'(j_s1) + D_W'(1);
		end else begin
			up = byp_s1 ? byp_data_s1 : rd_s1;
		end

		// candidates with saturation
		cu.m = up.m;
		cu.d = (up.d == D_MAX) ? D_MAX : up.d + D_W'(1);
		cl.m = lf.m;
		cl.d = (lf.d == D_MAX) ? D_MAX : lf.d + D_W'(1);
		dsum = (M_W+1)'(dg.m) + (M_W+1)'(score_s1);
		if (dsum > (M_W+1)'(M_MAX))
			cd.m = M_MAX;
		else if (dsum < (M_W+1)'(M_MIN))
			cd.m = M_MIN;
		else
			cd.m = dsum[M_W-1:0];
		cd.d = dg.d;

		r_cu = rank_of(cu, wm_q, wi_q);
		r_cl = rank_of(cl, wm_q, wi_q);
		r_cd = rank_of(cd, wm_q, wi_q);

		// up first; then left and diagonal, or diagonal and left in indel-first mode
		if (md == MODE_LEX_INDEL) begin
			best1   = better(cd, cu, r_cd, r_cu, md) ? cd : cu;
			r_best1 = better(cd, cu, r_cd, r_cu, md) ? r_cd : r_cu;
			best    = better(cl, best1, r_cl, r_best1, md) ? cl : best1;
		end else begin
			best1   = better(cl, cu, r_cl, r_cu, md) ? cl : cu;
			r_best1 = better(cl, cu, r_cl, r_cu, md) ? r_cl : r_cu;
			best    = better(cd, best1, r_cd, r_best1, md) ? cd : best1;
		end
	end

	// Result register
	pair_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_go && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1)
			out_q <= best;
	end

	assign m_tdata = {2'b00, out_q.d, out_q.m};

	// Checks
	a_last_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> m_tvalid)
		else $error("last cell did not load the result register");

	a_last_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tlast |=> col_q == '0 && row_q == '0)
		else $error("grid position not returned to origin after last cell");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> col_q < CNT_W'(MAX_COLS))
		else $error("column counter out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_go |=> s1_valid && $stable(j_s1) && $stable(left_q))
		else $error("stalled cell lost its state");

endmodule

@@ tb/baldp_grid_checker.sv @@
`timescale 1ns / 100ps
// Checker for the alignment grid block: tracks the grid, predicts final-cell results, compares.
module baldp_grid_checker
	import baldp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] score
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [17:0] final_matches, [29:18] final_indels
	output int          fail_count,
	output int          expected_left,
	output int          cells_seen,
	output int          finals_seen
);

	// Mirror of the grid state and the register file
	pair_t             prev_row [MAX_COLS];
	pair_t             left_pair;
	pair_t             diag_pair;
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [1:0]        mode_r;
	logic [W_W-1:0]    wm_r;
	logic [W_W-1:0]    wi_r;
	logic [CNT_W-1:0]  cols_r;

	// Final-cell pairs still owed by the block, oldest first
	pair_t             final_cells_q [$];
	pair_t             want;
	logic signed [M_W-1:0] got_m;
	logic [D_W-1:0]    got_d;

	function automatic logic [D_W-1:0] bump_indels(input logic [D_W-1:0] d);
		return (d == D_MAX) ? D_MAX : d + 1'b1;
	endfunction

	// True when a is strictly better than b under the given mode
	function automatic logic beats(input pair_t a, input pair_t b, input logic [1:0] md);
		longint ra;
		longint rb;
		if (md == MODE_LEX_INDEL) begin
			if (a.d != b.d)
				return a.d < b.d;
			return $signed(a.m) > $signed(b.m);
		end
		if (md == MODE_WEIGHTED) begin
			ra = longint'(wm_r) * longint'($signed(a.m)) - longint'(wi_r) * longint'(a.d);
			rb = longint'(wm_r) * longint'($signed(b.m)) - longint'(wi_r) * longint'(b.d);
			return ra > rb;
		end
		if ($signed(a.m) != $signed(b.m))
			return $signed(a.m) > $signed(b.m);
		return a.d < b.d;
	endfunction

	// One accepted cell: pick the best candidate and advance the grid position
	task automatic predict_cell(input logic [7:0] sc_bits, input logic is_last);
		int unsigned ncols;
		int unsigned j;
		logic [1:0]  md;
		pair_t       up_p;
		pair_t       lf_p;
		pair_t       dg_p;
		pair_t       c_up;
		pair_t       c_left;
		pair_t       c_diag;
		pair_t       pick;
		int          sum;

		ncols = (cols_r == 0) ? 1 : ((cols_r > MAX_COLS) ? MAX_COLS : cols_r);
		md    = (mode_r > MODE_WEIGHTED) ? MODE_LEX_MATCH : mode_r;
		if (col_pos >= ncols)
			col_pos = 0;
		j = col_pos;

		// column 0 takes its left and diagonal from the border
		if (j == 0) begin
			lf_p.m = '0;
			lf_p.d = D_W'(row_pos + 1);
			dg_p.m = '0;
			dg_p.d = D_W'(row_pos);
		end else begin
			lf_p = left_pair;
			dg_p = diag_pair;
		end
		if (row_pos == 0) begin
			up_p.m = '0;
			up_p.d = D_W'(j + 1);
		end else begin
			up_p = prev_row[j];
		end

		c_up.m   = up_p.m;
		c_up.d   = bump_indels(up_p.d);
		c_left.m = lf_p.m;
		c_left.d = bump_indels(lf_p.d);
		sum = int'($signed(dg_p.m)) + int'($signed(sc_bits));
		if (sum > int'(M_MAX))
			sum = int'(M_MAX);
		else if (sum < int'(M_MIN))
			sum = int'(M_MIN);
		c_diag.m = sum[M_W-1:0];
		c_diag.d = dg_p.d;

		// tie order differs in fewest-indels mode
		pick = c_up;
		if (md == MODE_LEX_INDEL) begin
			if (beats(c_diag, pick, md)) pick = c_diag;
			if (beats(c_left, pick, md)) pick = c_left;
		end else begin
			if (beats(c_left, pick, md)) pick = c_left;
			if (beats(c_diag, pick, md)) pick = c_diag;
		end

		diag_pair   = up_p;
		left_pair   = pick;
		prev_row[j] = pick;

		if (is_last) begin
			final_cells_q.push_back(pick);
			col_pos = 0;
			row_pos = 0;
		end else begin
			col_pos = j + 1;
			if (col_pos >= ncols) begin
				col_pos = 0;
				if (row_pos < MAX_ROWS - 1)
					row_pos++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_COLS; k++)
				prev_row[k] = '0;
			left_pair = '0;
			diag_pair = '0;
			col_pos   = 0;
			row_pos   = 0;
			mode_r    = MODE_LEX_MATCH;
			wm_r      = W_W'(1);
			wi_r      = W_W'(1);
			cols_r    = CNT_W'(MAX_COLS);
			final_cells_q.delete();
			fail_count  = 0;
			cells_seen  = 0;
			finals_seen = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_r = cfg_data[1:0];
					REG_WM:   wm_r   = cfg_data[W_W-1:0];
					REG_WI:   wi_r   = cfg_data[W_W-1:0];
					REG_COLS: cols_r = cfg_data;
					default: ;
				endcase
			end

			// result side
			if (m_tvalid && m_tready) begin
				finals_seen++;
				got_m = m_tdata[M_W-1:0];
				got_d = m_tdata[M_W+D_W-1:M_W];
				if (final_cells_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, matches %0d indels %0d",
						$time, got_m, got_d);
				end else begin
					want = final_cells_q.pop_front();
					if (got_m !== want.m) begin
						fail_count++;
						$display("%0t: final_matches expected %0d got %0d",
							$time, $signed(want.m), got_m);
					end
					if (got_d !== want.d) begin
						fail_count++;
						$display("%0t: final_indels expected %0d got %0d",
							$time, want.d, got_d);
					end
				end
			end

			// request side
			if (s_tvalid && s_tready) begin
				cells_seen++;
				predict_cell(s_tdata, s_tlast);
			end
		end
		expected_left = final_cells_q.size();
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the alignment grid block: clock, reset, stimulus, receiver stalls, verdict.
module tb_top;
	import baldp_pkg::*;

	// mode code that the block folds onto the most-matches mode
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef enum int {SC_RANDOM, SC_EXTREME, SC_NONPOS, SC_HIGH} score_kind_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_MODE;
	logic [10:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] score
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // [17:0] final_matches, [29:18] final_indels

	int fail_count;
	int expected_left;
	int cells_seen;
	int finals_seen;

	int cur_cols;
	int cells_sent;
	int grids_sent;
	int burst_left;
	bit hold_req;

	biobjective_alignment_bound_dp DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	baldp_grid_checker u_grid_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.expected_left (expected_left),
		.cells_seen    (cells_seen),
		.finals_seen   (finals_seen)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit
	initial begin
		#3_000_000;
		$display("%0t: timeout, %0d results still owed", $time, expected_left);
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: changing stall patterns, plus a long hold-off on request
	initial begin
		int style;
		int style_left;
		int hold_cycles;
		int tick;
		style       = 0;
		style_left  = 0;
		hold_cycles = 0;
		tick        = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_cycles = 400;
			end
			if (style_left == 0) begin
				style      = $urandom_range(0, 3);
				style_left = $urandom_range(16, 96);
			end
			style_left--;
			tick++;
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready = 1'b0;
			end else begin
				case (style)
					0: m_tready = 1'b1;
					1: m_tready = ($urandom_range(0, 1) == 1);
					2: m_tready = ($urandom_range(0, 3) == 0);
					default: m_tready = tick[2];
				endcase
			end
		end
	end

	// Offer one cell, with bursts and random gaps, and wait for acceptance
	task automatic send_cell(input logic [7:0] sc, input int lst);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 6);
		end
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata  = sc;
		s_tlast  = (lst != 0);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		cells_sent++;
		if (lst != 0)
			grids_sent++;
	endtask

	// Let every owed result drain, then let the result register settle
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (expected_left != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [10:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_config(input int md, input int wm, input int wi, input int cv);
		wait_idle();
		write_reg(REG_MODE, 11'(md));
		write_reg(REG_WM, 11'(wm));
		write_reg(REG_WI, 11'(wi));
		write_reg(REG_COLS, 11'(cv));
		cur_cols = (cv == 0) ? 1 : ((cv > MAX_COLS) ? MAX_COLS : cv);
	endtask

	function automatic logic [7:0] next_score(input score_kind_e kind);
		case (kind)
			SC_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return 8'h7F;
					1: return 8'h80;
					2: return 8'h00;
					3: return 8'h01;
					default: return 8'hFF;
				endcase
			end
			SC_NONPOS: return 8'(-$urandom_range(0, 128));
			SC_HIGH:   return 8'($urandom_range(96, 127));
			default:   return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One grid of rows x cur_cols cells; cut short ends it at a random cell
	task automatic run_grid(input int rows, input score_kind_e kind, input bit cut_short);
		int total;
		int stop;
		total = rows * cur_cols;
		stop  = cut_short ? $urandom_range(1, total) : total;
		for (int k = 0; k < stop; k++)
			send_cell(next_score(kind), k == stop - 1);
	endtask

	initial begin
		int nc;
		cur_cols   = MAX_COLS;
		cells_sent = 0;
		grids_sent = 0;
		burst_left = 0;
		hold_req   = 1'b0;

		// reset once
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: most matches, 2x3 grid with extreme scores
		set_config(MODE_LEX_MATCH, 1, 1, 3);
		send_cell(8'h7F, 0); send_cell(8'h80, 0); send_cell(8'h00, 0);
		send_cell(8'h80, 0); send_cell(8'h7F, 0); send_cell(8'h01, 1);

		// fewest indels, diagonal preferred over left on ties
		set_config(MODE_LEX_INDEL, 1, 1, 3);
		send_cell(8'h80, 0); send_cell(8'h80, 0); send_cell(8'h7F, 0);
		send_cell(8'h7F, 0); send_cell(8'h00, 0); send_cell(8'h80, 1);

		// weighted with both weights at their maximum
		set_config(MODE_WEIGHTED, 255, 255, 3);
		send_cell(8'h7F, 0); send_cell(8'h80, 0); send_cell(8'h7F, 0);
		send_cell(8'h01, 0); send_cell(8'hFF, 0); send_cell(8'h7F, 1);

		// spare mode code, column count of zero acts as one column
		set_config(MODE_SPARE, 1, 1, 0);
		send_cell(8'h7F, 0); send_cell(8'h80, 0); send_cell(8'h7F, 1);

		// zero weights; last cell arriving early, mid-row
		set_config(MODE_WEIGHTED, 0, 0, 2);
		send_cell(8'h80, 1);
		send_cell(8'h7F, 0); send_cell(8'h80, 0); send_cell(8'h00, 1);

		// back-pressure: output held off while single-cell grids keep coming
		set_config(MODE_LEX_INDEL, 7, 3, 1);
		hold_req = 1'b1;
		for (int k = 0; k < 16; k++)
			send_cell(next_score(SC_RANDOM), 1);

		// random phases of small grids, mostly complete, some cut short
		while (cells_sent < 400) begin
			case ($urandom_range(0, 9))
				0:       nc = 0;
				1:       nc = $urandom_range(16, 48);
				default: nc = $urandom_range(1, 8);
			endcase
			set_config($urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(0, 2047), nc);
			repeat ($urandom_range(1, 4))
				run_grid($urandom_range(1, 5), score_kind_e'($urandom_range(0, 3)),
					$urandom_range(0, 7) == 0);
		end

		// column count above the maximum: a partial first row ended early
		set_config(MODE_LEX_MATCH, 1, 1, 2047);
		for (int k = 0; k < 24; k++)
			send_cell(next_score(SC_RANDOM), k == 23);

		// single column, up always wins: indels climb row by row
		set_config(MODE_WEIGHTED, $urandom_range(1, 255), 0, 1);
		run_grid(40, SC_NONPOS, 1'b0);

		// drain and verdict
		s_tvalid = 1'b0;
		while (expected_left != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("Run covered %0d cells in %0d grids and checked %0d final-cell results,",
			cells_seen, grids_sent, finals_seen);
		$display("across all mode codes, column counts 0 to 2047 and a long output stall.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/baldp_pkg.sv
hw/rtl/biobjective_alignment_bound_dp.sv
tb/baldp_grid_checker.sv
tb/tb_top.sv
